FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Q-learning agent checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TQL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tql assertion failed");

// next-cycle implication
`define TQL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tql assertion failed");

`endif

FILE: design/tql_pkg.sv
// ----------------------------------------------------------------------------
// tql_pkg
// Types, field layout and constants of the tabular Q-learning agent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tql_pkg;

  localparam int NUM_ACTIONS = 5;
  localparam logic [2:0] ACT_LAST = 3'd4;

  localparam int STATE_W  = 10;
  localparam int ACT_W    = 3;
  localparam int Q_W      = 32;
  localparam int RAND_W   = 16;
  localparam int CFG_W    = 17;
  localparam int CNT_W    = 32;
  localparam int MOD_K_W  = 4;
  localparam int MOD_CMP_W = 26;

  // input tdata layout
  localparam int IN_STATE_LO = 0;
  localparam int IN_ACT_LO   = 10;
  localparam int IN_REW_LO   = 13;
  localparam int IN_NEXT_LO  = 45;
  localparam int IN_CD_BIT   = 55;
  localparam int IN_CS_BIT   = 56;
  localparam int IN_CSR_BIT  = 57;
  localparam int IN_DRAW_LO  = 58;
  localparam int IN_PICK_LO  = 74;
  localparam int IN_TDATA_W  = 96;

  // output tdata layout
  localparam int OUT_USED_W  = ACT_W + Q_W + CNT_W;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVAL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 2'd3;

  localparam logic [CFG_W-1:0] ONE_Q16       = 17'h10000;
  localparam logic [CFG_W-1:0] ALPHA_RST     = 17'd6554;
  localparam logic [CFG_W-1:0] GAMMA_RST     = 17'd62259;
  localparam logic [CFG_W-1:0] EPSILON_RST   = 17'd6554;

  // request kinds on tuser
  localparam logic REQ_DECIDE = 1'b0;
  localparam logic REQ_LEARN  = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] alpha;
    logic [CFG_W-1:0] gamma;
    logic             eval_mode;
    logic [CFG_W-1:0] epsilon;
  } cfg_t;

  typedef struct packed {
    logic               load;
    logic               mod_en;
    logic [MOD_K_W-1:0] mod_k;
    logic               clr_en;
    logic               rd_en;
    logic               rd_max;
    logic [ACT_W-1:0]   rd_act;
    logic               mul_g;
    logic               tgt_en;
    logic               mul_a;
    logic               wr_en;
    logic               res_en;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic req_learn;
    logic act_ok;
    logic is_term;
    logic explore;
    logic out_busy;
  } sts_t;

  function automatic logic [CFG_W-1:0] sat_one(logic [CFG_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // shift-subtract steps needed to fold a 10-bit index below n
  function automatic int mod_steps(int n);
    int c;
    c = 0;
    for (int k = 0; k < STATE_W; k++) begin
      if ((n << k) < (1 << STATE_W)) begin
        c = c + 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/tql_cfg.sv
// ----------------------------------------------------------------------------
// tql_cfg
// Configuration registers: alpha, gamma, evaluation mode, epsilon.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tql_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tql_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tql_pkg::CFG_W-1:0]          cfg_data_i,
  output tql_pkg::cfg_t                      cfg_o
);

  tql_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha     <= tql_pkg::ALPHA_RST;
      cfg_q.gamma     <= tql_pkg::GAMMA_RST;
      cfg_q.eval_mode <= 1'b0;
      cfg_q.epsilon   <= tql_pkg::EPSILON_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tql_pkg::REG_ALPHA:   cfg_q.alpha     <= tql_pkg::sat_one(cfg_data_i);
        tql_pkg::REG_GAMMA:   cfg_q.gamma     <= tql_pkg::sat_one(cfg_data_i);
        tql_pkg::REG_EVAL:    cfg_q.eval_mode <= cfg_data_i[0];
        tql_pkg::REG_EPSILON: cfg_q.epsilon   <= tql_pkg::sat_one(cfg_data_i);
        default: ;
      endcase
    end
  end

endmodule

FILE: design/tql_datapath.sv
// ----------------------------------------------------------------------------
// tql_datapath
// Q-table memory, index folding, max search, fixed-point update and result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tql_datapath #(
  parameter int NUM_STATES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tql_pkg::cmd_t                       cmd_i,
  output tql_pkg::sts_t                       sts_o,
  input  tql_pkg::cfg_t                       cfg_i,
  input  logic [tql_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic                                s_tuser_i,
  input  logic                                s_tlast_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [tql_pkg::OUT_TDATA_W-1:0]     m_tdata_o
);

  localparam int DEPTH = NUM_STATES * tql_pkg::NUM_ACTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int AXW   = (AW > 13) ? AW : 13;
  localparam logic [tql_pkg::MOD_CMP_W-1:0] NS_CMP = tql_pkg::MOD_CMP_W'(NUM_STATES);

  // item fields
  logic                             req_q;
  logic [tql_pkg::STATE_W-1:0]      s_q;
  logic [tql_pkg::ACT_W-1:0]        act_q;
  logic signed [tql_pkg::Q_W-1:0]   rew_q;
  logic                             term_q;
  logic [tql_pkg::STATE_W-1:0]      ns_q;
  logic                             cd_q;
  logic                             cs_q;
  logic                             csr_q;
  logic [tql_pkg::RAND_W-1:0]       draw_q;
  logic [tql_pkg::RAND_W-1:0]       pick_q;

  // memory
  logic [tql_pkg::Q_W-1:0]          mem [DEPTH];
  logic [tql_pkg::Q_W-1:0]          rdata_q;
  logic [AW-1:0]                    mem_addr;
  logic                             mem_we;
  logic [tql_pkg::Q_W-1:0]          mem_wdata;
  logic [AW-1:0]                    clr_addr_q;
  logic [tql_pkg::STATE_W-1:0]      row;
  logic [tql_pkg::ACT_W-1:0]        act_sel;
  logic [AXW-1:0]                   addr_full;

  // max search
  logic                             max_vld_q;
  logic                             max_first_q;
  logic [tql_pkg::ACT_W-1:0]        max_act_q;
  logic signed [tql_pkg::Q_W-1:0]   best_val_q;
  logic [tql_pkg::ACT_W-1:0]        best_act_q;
  logic signed [tql_pkg::Q_W-1:0]   rdata_s;

  // index folding
  logic [tql_pkg::MOD_CMP_W-1:0]    mod_sub;

  // arithmetic
  logic signed [17:0]               gamma_s;
  logic signed [17:0]               alpha_s;
  logic signed [49:0]               prod_g_q;
  logic signed [49:0]               g_sum;
  logic signed [33:0]               g_rnd;
  logic signed [35:0]               g_add;
  logic signed [35:0]               diff_d;
  logic signed [35:0]               diff_q;
  logic signed [tql_pkg::Q_W-1:0]   cur_q;
  logic signed [53:0]               prod_a_q;
  logic signed [53:0]               a_sum;
  logic signed [37:0]               a_rnd;
  logic signed [38:0]               nq_w;
  logic [tql_pkg::Q_W-1:0]          nq_sat;
  logic [tql_pkg::Q_W-1:0]          nq_q;
  logic [tql_pkg::CNT_W-1:0]        cnt_q;

  // exploration pick
  logic [2:0]                       legal_cnt;
  logic [18:0]                      pick_prod;
  logic [2:0]                       slot;
  logic [4:0]                       legal;
  logic [2:0]                       idx;
  logic [tql_pkg::ACT_W-1:0]        pick_act;
  logic                             explore;
  logic                             act_ok;

  // result register
  logic                             out_valid_q;
  logic [tql_pkg::ACT_W-1:0]        out_act_q;
  logic [tql_pkg::Q_W-1:0]          out_nq_q;
  logic [tql_pkg::CNT_W-1:0]        out_cnt_q;

  assign mod_sub = NS_CMP << cmd_i.mod_k;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= s_tuser_i;
      s_q    <= s_tdata_i[tql_pkg::IN_STATE_LO +: tql_pkg::STATE_W];
      act_q  <= s_tdata_i[tql_pkg::IN_ACT_LO +: tql_pkg::ACT_W];
      rew_q  <= s_tdata_i[tql_pkg::IN_REW_LO +: tql_pkg::Q_W];
      term_q <= s_tlast_i;
      ns_q   <= s_tdata_i[tql_pkg::IN_NEXT_LO +: tql_pkg::STATE_W];
      cd_q   <= s_tdata_i[tql_pkg::IN_CD_BIT];
      cs_q   <= s_tdata_i[tql_pkg::IN_CS_BIT];
      csr_q  <= s_tdata_i[tql_pkg::IN_CSR_BIT];
      draw_q <= s_tdata_i[tql_pkg::IN_DRAW_LO +: tql_pkg::RAND_W];
      pick_q <= s_tdata_i[tql_pkg::IN_PICK_LO +: tql_pkg::RAND_W];
    end else if (cmd_i.mod_en) begin
      if (tql_pkg::MOD_CMP_W'(s_q) >= mod_sub) begin
        s_q <= s_q - mod_sub[tql_pkg::STATE_W-1:0];
      end
      if (tql_pkg::MOD_CMP_W'(ns_q) >= mod_sub) begin
        ns_q <= ns_q - mod_sub[tql_pkg::STATE_W-1:0];
      end
    end
  end

  assign row       = (cmd_i.rd_max && (req_q == tql_pkg::REQ_LEARN)) ? ns_q : s_q;
  assign act_sel   = cmd_i.rd_max ? cmd_i.rd_act : act_q;
  assign addr_full = AXW'(row) * AXW'(tql_pkg::NUM_ACTIONS) + AXW'(act_sel);
  assign mem_addr  = cmd_i.clr_en ? clr_addr_q : addr_full[AW-1:0];
  assign mem_we    = cmd_i.clr_en | cmd_i.wr_en;
  assign mem_wdata = cmd_i.clr_en ? '0 : nq_sat;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  assign rdata_s = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      max_vld_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      max_vld_q <= cmd_i.rd_en & cmd_i.rd_max;
      if (cmd_i.wr_en && (cnt_q != '1)) begin
        cnt_q <= cnt_q + tql_pkg::CNT_W'(1);
      end
      if (cmd_i.res_en) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // fixed-point update
  assign gamma_s = {1'b0, cfg_i.gamma};
  assign alpha_s = {1'b0, cfg_i.alpha};
  assign g_sum   = prod_g_q + 50'sd32768;
  assign g_rnd   = g_sum[49:16];
  assign g_add   = term_q ? 36'sd0 : 36'(g_rnd);
  assign diff_d  = 36'(rew_q) + g_add - 36'(rdata_s);
  assign a_sum   = prod_a_q + 54'sd32768;
  assign a_rnd   = a_sum[53:16];
  assign nq_w    = 39'(cur_q) + 39'(a_rnd);

  always_comb begin
    if (nq_w > 39'sd2147483647) begin
      nq_sat = 32'h7FFF_FFFF;
    end else if (nq_w < -39'sd2147483648) begin
      nq_sat = 32'h8000_0000;
    end else begin
      nq_sat = nq_w[tql_pkg::Q_W-1:0];
    end
  end

  // exploration pick
  assign legal_cnt = 3'd2 + 3'(cd_q) + 3'(cs_q) + 3'(csr_q);
  assign pick_prod = 19'(pick_q) * 19'(legal_cnt);
  assign slot      = pick_prod[18:16];
  assign legal     = {csr_q, cs_q, cd_q, 2'b11};
  assign explore   = !cfg_i.eval_mode && (tql_pkg::CFG_W'(draw_q) < cfg_i.epsilon);
  assign act_ok    = act_q <= tql_pkg::ACT_LAST;

  always_comb begin
    idx      = '0;
    pick_act = '0;
    for (int a = 0; a < tql_pkg::NUM_ACTIONS; a++) begin
      if (legal[a]) begin
        if (idx == slot) begin
          pick_act = 3'(a);
        end
        idx = idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    max_first_q <= cmd_i.rd_act == '0;
    max_act_q   <= cmd_i.rd_act;
    if (max_vld_q && (max_first_q || (rdata_s > best_val_q))) begin
      best_val_q <= rdata_s;
      best_act_q <= max_act_q;
    end
    if (cmd_i.mul_g) begin
      prod_g_q <= gamma_s * best_val_q;
    end
    if (cmd_i.tgt_en) begin
      diff_q <= diff_d;
      cur_q  <= rdata_s;
    end
    if (cmd_i.mul_a) begin
      prod_a_q <= alpha_s * diff_q;
    end
    if (cmd_i.wr_en) begin
      nq_q <= nq_sat;
    end
    if (cmd_i.res_en) begin
      out_act_q <= (req_q == tql_pkg::REQ_LEARN) ? '0 : (explore ? pick_act : best_act_q);
      out_nq_q  <= ((req_q == tql_pkg::REQ_LEARN) && act_ok) ? nq_q : '0;
      out_cnt_q <= cnt_q;
    end
  end

  assign sts_o.clr_done  = clr_addr_q == AW'(DEPTH - 1);
  assign sts_o.req_learn = req_q == tql_pkg::REQ_LEARN;
  assign sts_o.act_ok    = act_ok;
  assign sts_o.is_term   = term_q;
  assign sts_o.explore   = explore;
  assign sts_o.out_busy  = out_valid_q && !m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{tql_pkg::OUT_PAD_W{1'b0}}, out_cnt_q, out_nq_q, out_act_q};

endmodule

FILE: design/tql_ctrl.sv
// ----------------------------------------------------------------------------
// tql_ctrl
// Sequencer: table clear after reset, index folding, table reads, update
// steps and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tql_ctrl #(
  parameter int MOD_STEPS = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  tql_pkg::sts_t sts_i,
  output tql_pkg::cmd_t cmd_o
);

  localparam logic [tql_pkg::MOD_K_W-1:0] MOD_TOP = tql_pkg::MOD_K_W'(MOD_STEPS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_DISPATCH,
    ST_MAX_RD,
    ST_MAX_WAIT,
    ST_GMUL,
    ST_TGT,
    ST_AMUL,
    ST_WRITE,
    ST_RESULT
  } state_e;

  state_e                       state_q;
  logic [tql_pkg::MOD_K_W-1:0]  cnt_q;

  assign s_tready_o = state_q == ST_IDLE;

  always_comb begin
    cmd_o        = '0;
    cmd_o.mod_k  = cnt_q;
    cmd_o.rd_act = cnt_q[tql_pkg::ACT_W-1:0];
    unique case (state_q)
      ST_CLEAR:    cmd_o.clr_en = 1'b1;
      ST_IDLE:     cmd_o.load   = s_tvalid_i;
      ST_MOD:      cmd_o.mod_en = 1'b1;
      ST_MAX_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_max = 1'b1;
      end
      ST_GMUL: begin
        cmd_o.mul_g = 1'b1;
        cmd_o.rd_en = 1'b1;
      end
      ST_TGT:      cmd_o.tgt_en = 1'b1;
      ST_AMUL:     cmd_o.mul_a  = 1'b1;
      ST_WRITE:    cmd_o.wr_en  = 1'b1;
      ST_RESULT:   cmd_o.res_en = !sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid_i) begin
            cnt_q   <= MOD_TOP;
            state_q <= (MOD_STEPS > 0) ? ST_MOD : ST_DISPATCH;
          end
        end
        ST_MOD: begin
          if (cnt_q == '0) begin
            state_q <= ST_DISPATCH;
          end else begin
            cnt_q <= cnt_q - tql_pkg::MOD_K_W'(1);
          end
        end
        ST_DISPATCH: begin
          cnt_q <= '0;
          priority if (sts_i.req_learn && !sts_i.act_ok) begin
            state_q <= ST_RESULT;
          end else if (sts_i.req_learn && sts_i.is_term) begin
            state_q <= ST_GMUL;
          end else if (!sts_i.req_learn && sts_i.explore) begin
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_MAX_RD;
          end
        end
        ST_MAX_RD: begin
          if (cnt_q[tql_pkg::ACT_W-1:0] == tql_pkg::ACT_LAST) begin
            state_q <= ST_MAX_WAIT;
          end else begin
            cnt_q <= cnt_q + tql_pkg::MOD_K_W'(1);
          end
        end
        ST_MAX_WAIT: state_q <= sts_i.req_learn ? ST_GMUL : ST_RESULT;
        ST_GMUL:     state_q <= ST_TGT;
        ST_TGT:      state_q <= ST_AMUL;
        ST_AMUL:     state_q <= ST_WRITE;
        ST_WRITE:    state_q <= ST_RESULT;
        ST_RESULT: begin
          if (!sts_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/tabular_q_learning_agent_top.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_top
// Tabular Q-learning agent, five actions per state, signed Q16.16 values.
//
// After reset the table is swept to zero, one entry per cycle, across all
// NUM_STATES*5 entries; s_tready_o stays low during the sweep while the
// configuration port is already open. Items are processed one at a time
// through a single-port table memory, with one result transaction per item.
// Each accepted item first takes F index-folding steps (F is 0 when
// NUM_STATES >= 1024, otherwise the number of shifts of NUM_STATES that stay
// below 1024). An exploring decide and a learn with an action above 4 then go
// straight to the result; a greedy decide and a non-terminal learn read the
// five actions of a state one after another; the learn path adds two
// registered multiplies and the write-back. The next item is taken while a
// result waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tabular_q_learning_agent_top #(
  parameter int NUM_STATES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tql_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tql_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // state_index, action, reward, next_state_index, can_double, can_split,
  // can_surrender, random_draw, random_pick, zero pad
  input  logic [tql_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  // req_type
  input  logic                               s_tuser_i,
  // is_terminal
  input  logic                               s_tlast_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // chosen_action, new_q, updates_done, zero pad
  output logic [tql_pkg::OUT_TDATA_W-1:0]    m_tdata_o
);

  localparam int MOD_STEPS = tql_pkg::mod_steps(NUM_STATES);

  tql_pkg::cfg_t cfg;
  tql_pkg::cmd_t cmd;
  tql_pkg::sts_t sts;

  tql_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tql_ctrl #(
    .MOD_STEPS (MOD_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tql_datapath #(
    .NUM_STATES (NUM_STATES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_i      (cfg),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tready_i (m_tready_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

FILE: design/tql_checker.sv
// ----------------------------------------------------------------------------
// tql_checker
// Port-level checks of the Q-learning agent, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tql_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_tvalid_i,
  input logic                             s_tready_o,
  input logic                             m_tvalid_o,
  input logic                             m_tready_i,
  input logic [tql_pkg::OUT_TDATA_W-1:0]  m_tdata_o
);

  `TQL_ASSERT_NXT(a_one_item_at_a_time, clk_i, rst_ni, s_tvalid_i && s_tready_o, !s_tready_o)
  `TQL_ASSERT_IMP(a_action_range, clk_i, rst_ni, m_tvalid_o, m_tdata_o[2:0] <= tql_pkg::ACT_LAST)
  `TQL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o)
  `TQL_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_tvalid_o && !m_tready_i, $stable(m_tdata_o))

endmodule

bind tabular_q_learning_agent_top tql_checker u_tql_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for tabular_q_learning_agent_top. Decide and learn
// transactions are sent on the input stream. The expected results come from
// a predictor that keeps its own Q table, learn counter and register copy.
// Results are compared in order, field by field. The run opens with directed
// cases: value and index extremes, exploration slots, saturation, an
// out-of-range action, and epsilon and alpha at their limits. Random episodes
// follow under several register settings, with random idling on both sides,
// one stretch without idling and one long output hold-off.
// ----------------------------------------------------------------------------

module testbench;
  import tql_pkg::*;

  localparam int NUM_STATES      = 1024;
  localparam int TABLE_DEPTH     = NUM_STATES * NUM_ACTIONS;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 285;
  localparam int HOT_STATES      = 6;
  localparam int MAX_PRINTS      = 100;

  localparam logic [ACT_W-1:0] ACT_HIT       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STAND     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DOUBLE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SPLIT     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SURRENDER = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BAD       = 3'd7;

  localparam logic MODE_TRAIN = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic                  kind;
    logic [STATE_W-1:0]    state;
    logic [ACT_W-1:0]      act;
    logic signed [Q_W-1:0] reward;
    logic                  term;
    logic [STATE_W-1:0]    next_state;
    logic                  can_double;
    logic                  can_split;
    logic                  can_surrender;
    logic [RAND_W-1:0]     draw;
    logic [RAND_W-1:0]     pick;
  } agent_req_t;

  typedef struct {
    logic [ACT_W-1:0] chosen;
    logic [Q_W-1:0]   new_q;
    logic [CNT_W-1:0] updates;
  } agent_res_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i  = '0;
  logic                   s_tvalid_i  = 1'b0;
  logic                   s_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata_i   = '0;
  logic                   s_tuser_i   = 1'b0;
  logic                   s_tlast_i   = 1'b0;
  logic                   m_tvalid_o;
  logic                   m_tready_i  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata_o;

  tabular_q_learning_agent_top #(
    .NUM_STATES(NUM_STATES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  // predictor state
  logic signed [Q_W-1:0] q_table [TABLE_DEPTH];
  logic [CNT_W-1:0]      learn_count;
  logic [CFG_W-1:0]      alpha_q;
  logic [CFG_W-1:0]      gamma_q;
  logic                  eval_q;
  logic [CFG_W-1:0]      epsilon_q;

  agent_req_t  pending_requests [$];
  agent_res_t  expected_results [$];
  agent_req_t  drive_req;
  logic        in_taken       = 1'b0;
  logic        offering       = 1'b0;
  logic        tx_no_idle     = 1'b0;
  logic        rx_no_idle     = 1'b0;
  logic        rx_hold_req    = 1'b0;
  logic        rx_hold_seen   = 1'b0;
  int          rx_hold_left   = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint round_q16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [ACT_W-1:0] greedy_action(int unsigned s);
    logic [ACT_W-1:0] best;
    longint           best_q;
    best   = ACT_HIT;
    best_q = longint'(q_table[s * NUM_ACTIONS]);
    for (int a = 1; a < NUM_ACTIONS; a++) begin
      if (longint'(q_table[s * NUM_ACTIONS + a]) > best_q) begin
        best_q = longint'(q_table[s * NUM_ACTIONS + a]);
        best   = a[ACT_W-1:0];
      end
    end
    return best;
  endfunction

  function automatic agent_res_t predict_agent_step(agent_req_t r);
    agent_res_t       res;
    int unsigned      s;
    int unsigned      ns;
    int unsigned      count;
    int unsigned      slot;
    logic [ACT_W-1:0] legal [NUM_ACTIONS];
    longint           cur;
    longint           target;
    longint           mq;
    longint           nq;
    res.chosen = ACT_HIT;
    res.new_q  = '0;
    s  = r.state % NUM_STATES;
    ns = r.next_state % NUM_STATES;
    if (r.kind == REQ_DECIDE) begin
      if (eval_q == MODE_TRAIN && r.draw < epsilon_q) begin
        legal[0] = ACT_HIT;
        legal[1] = ACT_STAND;
        count    = 2;
        if (r.can_double) begin
          legal[count] = ACT_DOUBLE;
          count++;
        end
        if (r.can_split) begin
          legal[count] = ACT_SPLIT;
          count++;
        end
        if (r.can_surrender) begin
          legal[count] = ACT_SURRENDER;
          count++;
        end
        slot       = (r.pick * count) >> 16;
        res.chosen = legal[slot];
      end else begin
        res.chosen = greedy_action(s);
      end
    end else if (r.act <= ACT_LAST) begin
      cur    = longint'(q_table[s * NUM_ACTIONS + r.act]);
      target = longint'(r.reward);
      if (!r.term) begin
        mq     = longint'(q_table[ns * NUM_ACTIONS + greedy_action(ns)]);
        target = target + round_q16(longint'(gamma_q) * mq);
      end
      nq = cur + round_q16(longint'(alpha_q) * (target - cur));
      if (nq > SAT_HI) nq = SAT_HI;
      if (nq < SAT_LO) nq = SAT_LO;
      q_table[s * NUM_ACTIONS + r.act] = nq[Q_W-1:0];
      res.new_q = nq[Q_W-1:0];
      if (learn_count != '1) learn_count++;
    end
    res.updates = learn_count;
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] random_setting();
    case ($urandom_range(5))
      0: return '0;
      1: return ONE_Q16;
      2: return CFG_W'($urandom_range(131071, 65537));
      3: return CFG_W'($urandom_range(16384));
      default: return CFG_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic queue_request(logic kind, int state, logic [ACT_W-1:0] act,
                               logic [Q_W-1:0] reward, logic term, int next_state,
                               int cd, int cs, int csr, int draw, int pick);
    agent_req_t r;
    r.kind          = kind;
    r.state         = STATE_W'(state);
    r.act           = act;
    r.reward        = reward;
    r.term          = term;
    r.next_state    = STATE_W'(next_state);
    r.can_double    = cd[0];
    r.can_split     = cs[0];
    r.can_surrender = csr[0];
    r.draw          = RAND_W'(draw);
    r.pick          = RAND_W'(pick);
    pending_requests.push_back(r);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ALPHA:   alpha_q   = (data > ONE_Q16) ? ONE_Q16 : data;
      REG_GAMMA:   gamma_q   = (data > ONE_Q16) ? ONE_Q16 : data;
      REG_EVAL:    eval_q    = data[0];
      REG_EPSILON: epsilon_q = (data > ONE_Q16) ? ONE_Q16 : data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || offering || expected_results.size() != 0);
  endtask

  // input stream driver
  always @(negedge clk_i) begin : drive_requests
    logic [IN_TDATA_W-1:0] beat;
    if (rst_ni && (!s_tvalid_i || in_taken)) begin
      in_taken = 1'b0;
      if (pending_requests.size() != 0 && (tx_no_idle || $urandom_range(99) >= 15)) begin
        drive_req = pending_requests.pop_front();
        beat = '0;
        beat[IN_STATE_LO +: STATE_W] = drive_req.state;
        beat[IN_ACT_LO +: ACT_W]     = drive_req.act;
        beat[IN_REW_LO +: Q_W]       = drive_req.reward;
        beat[IN_NEXT_LO +: STATE_W]  = drive_req.next_state;
        beat[IN_CD_BIT]              = drive_req.can_double;
        beat[IN_CS_BIT]              = drive_req.can_split;
        beat[IN_CSR_BIT]             = drive_req.can_surrender;
        beat[IN_DRAW_LO +: RAND_W]   = drive_req.draw;
        beat[IN_PICK_LO +: RAND_W]   = drive_req.pick;
        s_tdata_i  <= beat;
        s_tuser_i  <= drive_req.kind;
        s_tlast_i  <= drive_req.term;
        s_tvalid_i <= 1'b1;
        offering = 1'b1;
      end else begin
        s_tvalid_i <= 1'b0;
        offering = 1'b0;
      end
    end
  end

  // output stream backpressure
  always @(negedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      m_tready_i   <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready_i   <= 1'b0;
    end else begin
      m_tready_i <= rx_no_idle || ($urandom_range(99) >= 15);
    end
  end

  // check results first, then predict for the input transaction of this edge
  always @(posedge clk_i) begin : monitor
    agent_res_t exp_res;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata_o[63:0], 64'd0);
      end else begin
        exp_res = expected_results.pop_front();
        if (m_tdata_o[0 +: ACT_W] !== exp_res.chosen)
          report_mismatch("chosen_action", 64'(m_tdata_o[0 +: ACT_W]), 64'(exp_res.chosen));
        if (m_tdata_o[ACT_W +: Q_W] !== exp_res.new_q)
          report_mismatch("new_q", 64'(m_tdata_o[ACT_W +: Q_W]), 64'(exp_res.new_q));
        if (m_tdata_o[ACT_W + Q_W +: CNT_W] !== exp_res.updates)
          report_mismatch("updates_done", 64'(m_tdata_o[ACT_W + Q_W +: CNT_W]),
                          64'(exp_res.updates));
      end
    end
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      expected_results.push_back(predict_agent_step(drive_req));
      in_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tabular_q_learning_agent_top regression: fail");
      $finish;
    end
  end

  initial begin : sequencer
    int               hot [HOT_STATES];
    int               cur_state;
    int               next_state;
    logic             kind;
    logic             term;
    logic [ACT_W-1:0] act;
    logic [Q_W-1:0]   reward;

    foreach (q_table[i]) q_table[i] = '0;
    learn_count = '0;
    alpha_q     = ALPHA_RST;
    gamma_q     = GAMMA_RST;
    eval_q      = MODE_TRAIN;
    epsilon_q   = EPSILON_RST;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extremes, out-of-range action, exploration slots
    queue_request(REQ_LEARN, 0, ACT_HIT, Q_MAX, 1'b1, 0, 0, 0, 0, 0, 0);
    queue_request(REQ_LEARN, 1023, ACT_SURRENDER, Q_MIN, 1'b1, 0, 0, 0, 0, 0, 0);
    queue_request(REQ_LEARN, 3, ACT_BAD, 32'h0001_2345, 1'b0, 1023, 1, 1, 1, 65535, 65535);
    queue_request(REQ_LEARN, 2, ACT_STAND, 32'h0001_0000, 1'b0, 1023, 0, 0, 0, 0, 0);
    queue_request(REQ_LEARN, 2, ACT_DOUBLE, 32'hFFFF_0000, 1'b0, 0, 0, 0, 0, 0, 0);
    queue_request(REQ_DECIDE, 1023, ACT_HIT, '0, 1'b0, 0, 0, 0, 0, 65535, 0);
    queue_request(REQ_DECIDE, 2, ACT_HIT, '0, 1'b0, 0, 0, 0, 0, 65535, 0);
    queue_request(REQ_DECIDE, 0, ACT_HIT, '0, 1'b0, 0, 1, 1, 1, 0, 0);
    queue_request(REQ_DECIDE, 0, ACT_HIT, '0, 1'b0, 0, 1, 1, 1, 0, 65535);
    queue_request(REQ_DECIDE, 0, ACT_HIT, '0, 1'b0, 0, 0, 0, 0, 0, 65535);
    queue_request(REQ_DECIDE, 0, ACT_HIT, '0, 1'b0, 0, 0, 1, 0, 0, 65535);
    queue_request(REQ_DECIDE, 0, ACT_HIT, '0, 1'b0, 0, 1, 0, 0, 0, 65535);
    queue_request(REQ_DECIDE, 2, ACT_HIT, '0, 1'b0, 0, 0, 0, 1, 6553, 65535);
    queue_request(REQ_DECIDE, 2, ACT_HIT, '0, 1'b0, 0, 0, 0, 1, 6554, 65535);
    wait_drained();

    // alpha and gamma at one, no exploration: saturate both ways
    write_register(REG_ALPHA, 17'h1FFFF);
    write_register(REG_GAMMA, ONE_Q16);
    write_register(REG_EPSILON, '0);
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      queue_request(REQ_LEARN, 5, a[ACT_W-1:0], Q_MIN, 1'b1, 0, 0, 0, 0, 0, 0);
    end
    queue_request(REQ_LEARN, 6, ACT_HIT, Q_MIN, 1'b0, 5, 0, 0, 0, 0, 0);
    queue_request(REQ_LEARN, 7, ACT_HIT, Q_MAX, 1'b1, 0, 0, 0, 0, 0, 0);
    queue_request(REQ_LEARN, 8, ACT_HIT, Q_MAX, 1'b0, 7, 0, 0, 0, 0, 0);
    queue_request(REQ_DECIDE, 5, ACT_HIT, '0, 1'b0, 0, 1, 1, 1, 0, 0);
    wait_drained();

    // greedy only, alpha zero
    write_register(REG_ALPHA, '0);
    write_register(REG_EPSILON, ONE_Q16);
    write_register(REG_EVAL, 17'(MODE_EVAL));
    queue_request(REQ_DECIDE, 8, ACT_HIT, '0, 1'b0, 0, 1, 1, 1, 0, 0);
    queue_request(REQ_LEARN, 8, ACT_STAND, Q_MAX, 1'b1, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // epsilon at one always explores
    write_register(REG_EVAL, 17'(MODE_TRAIN));
    queue_request(REQ_DECIDE, 5, ACT_HIT, '0, 1'b0, 0, 1, 1, 1, 65535, 65535);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_register(REG_ALPHA, random_setting());
      write_register(REG_GAMMA, random_setting());
      write_register(REG_EVAL, (ph == 4 || $urandom_range(3) == 0) ? 17'h1FFFF : 17'h1FFFE);
      write_register(REG_EPSILON, random_setting());
      foreach (hot[i]) hot[i] = $urandom_range(1023);
      tx_no_idle = (ph == 1 || ph == 3);
      rx_no_idle = (ph == 1);
      if (ph == 3) rx_hold_req = ~rx_hold_req;
      cur_state = hot[0];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = ($urandom_range(99) < 45) ? REQ_DECIDE : REQ_LEARN;
        next_state = ($urandom_range(99) < 85) ? hot[$urandom_range(HOT_STATES - 1)]
                                               : $urandom_range(1023);
        act = ($urandom_range(99) < 90) ? ACT_W'($urandom_range(4))
                                        : ACT_W'($urandom_range(7, 5));
        case ($urandom_range(9))
          0:       reward = Q_MAX;
          1:       reward = Q_MIN;
          2, 3:    reward = $urandom();
          default: reward = $urandom_range(524288) - 262144;
        endcase
        term = ($urandom_range(99) < 30);
        queue_request(kind, cur_state, act, reward, term, next_state,
                      $urandom_range(1), $urandom_range(1), $urandom_range(1),
                      $urandom_range(65535), $urandom_range(65535));
        if (kind == REQ_LEARN) begin
          cur_state = term ? hot[$urandom_range(HOT_STATES - 1)] : next_state;
        end
        if ($urandom_range(99) < 5) cur_state = $urandom_range(1023);
      end
      wait_drained();
    end

    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tabular_q_learning_agent_top regression: pass");
    end else begin
      $display("tabular_q_learning_agent_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/tql_pkg.sv
design/tql_cfg.sv
design/tql_datapath.sv
design/tql_ctrl.sv
design/tabular_q_learning_agent_top.sv
design/tql_checker.sv
tb/testbench.sv
